/* src/qec_pkg.sv */
package qec_pkg;

   localparam int PIN_BITS        = 5;
   localparam int OUT_FIELDS      = 5;
   localparam int OUT_WIDTH       = 32;
   localparam int SUB_WIDTH       = 16;
   localparam int DIV_WIDTH       = 15;
   localparam int DIVIDED_CHANNEL = 4;
   localparam int REQ_DATA_WIDTH  = 16;
   localparam int RSP_DATA_WIDTH  = OUT_FIELDS * OUT_WIDTH;
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [0:0] CSR_INVERT_MASK = 1'd0;
   localparam logic [0:0] CSR_DIVIDER     = 1'd1;

   localparam logic [DIV_WIDTH-1:0] DIVIDER_RESET = 15'd100;

   typedef struct packed {
      logic a;
      logic b;
      logic prev_a;
      logic clear;
      logic invert;
   } lane_pins_type;

endpackage

/* src/qec_lane.sv */
module qec_lane #(
   parameter int COUNT_WIDTH = 32,
   parameter bit DIVIDED     = 1'b0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  qec_pkg::lane_pins_type          pins,
   input  logic [qec_pkg::DIV_WIDTH-1:0]   divider,
   output logic [COUNT_WIDTH-1:0]          count_next
);

   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic [COUNT_WIDTH-1:0] count_up;
   logic [COUNT_WIDTH-1:0] count_down;
   logic                   moved;
   logic                   up;

   assign moved      = pins.a ^ pins.prev_a;
   assign up         = ~(pins.a ^ pins.b) ^ pins.invert;
   assign count_up   = count_ff + COUNT_WIDTH'(1);
   assign count_down = count_ff - COUNT_WIDTH'(1);
   assign count_next = count_in;

   generate
      if (DIVIDED) begin : g_divided
         localparam int SumWidth = qec_pkg::SUB_WIDTH + 1;

         logic signed [qec_pkg::SUB_WIDTH-1:0] sub_ff;
         logic signed [qec_pkg::SUB_WIDTH-1:0] sub_in;
         logic signed [SumWidth-1:0]           sub_sum;
         logic signed [SumWidth-1:0]           div_pos;
         logic signed [SumWidth-1:0]           div_neg;
         logic [qec_pkg::DIV_WIDTH-1:0]        div_eff;

         // A divider of zero behaves as a divider of one.
         assign div_eff = (divider == '0) ? qec_pkg::DIV_WIDTH'(1) : divider;
         assign div_pos = signed'({{(SumWidth - qec_pkg::DIV_WIDTH){1'b0}}, div_eff});
         assign div_neg = -div_pos;
         assign sub_sum = {sub_ff[qec_pkg::SUB_WIDTH-1], sub_ff}
                        + (up ? SumWidth'(1) : {SumWidth{1'b1}});

         always_comb begin
            count_in = count_ff;
            sub_in   = sub_ff;
            if (accept) begin
               if (pins.clear) begin
                  count_in = '0;
                  sub_in   = '0;
               end else if (moved) begin
                  if (sub_sum >= div_pos) begin
                     count_in = count_up;
                     sub_in   = qec_pkg::SUB_WIDTH'(sub_sum - div_pos);
                  end else if (sub_sum <= div_neg) begin
                     count_in = count_down;
                     sub_in   = qec_pkg::SUB_WIDTH'(sub_sum + div_pos);
                  end else begin
                     sub_in   = qec_pkg::SUB_WIDTH'(sub_sum);
                  end
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               sub_ff <= '0;
            end else begin
               sub_ff <= sub_in;
            end
         end
      end else begin : g_plain
         always_comb begin
            count_in = count_ff;
            if (accept) begin
               if (pins.clear) begin
                  count_in = '0;
               end else if (moved) begin
                  count_in = up ? count_up : count_down;
               end
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      (accept && pins.clear) |=> (count_ff == '0))
      else $error("Count is not zero after a clear.");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("Count changed without an accepted item.");

   a_no_edge_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && !pins.clear && !moved) |=> $stable(count_ff))
      else $error("Count changed without an A edge.");

endmodule

/* src/qec_merge.sv */
module qec_merge #(
   parameter int LANES       = 5,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     load,
   input  logic [LANES-1:0][COUNT_WIDTH-1:0]        counts,
   input  logic                                     rsp_tready,
   output logic                                     rsp_tvalid,
   output logic [qec_pkg::RSP_DATA_WIDTH-1:0]       rsp_tdata,
   output logic                                     space
);

   logic [qec_pkg::OUT_FIELDS-1:0][qec_pkg::OUT_WIDTH-1:0] fields;
   logic [qec_pkg::RSP_DATA_WIDTH-1:0]                     tdata_ff;
   logic                                                   tvalid_ff;
   logic                                                   tvalid_in;

   generate
      for (genvar i = 0; i < qec_pkg::OUT_FIELDS; i++) begin : g_field
         if (i >= LANES) begin : g_absent
            assign fields[i] = '0;
         end else if (COUNT_WIDTH >= qec_pkg::OUT_WIDTH) begin : g_trunc
            assign fields[i] = counts[i][qec_pkg::OUT_WIDTH-1:0];
         end else begin : g_extend
            assign fields[i] = {{(qec_pkg::OUT_WIDTH - COUNT_WIDTH){counts[i][COUNT_WIDTH-1]}},
                                counts[i]};
         end
      end
   endgenerate

   assign space     = !tvalid_ff || rsp_tready;
   assign tvalid_in = load || (tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         tvalid_ff <= 1'b0;
      end else begin
         tvalid_ff <= tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tdata_ff <= fields;
      end
   end

   assign rsp_tvalid = tvalid_ff;
   assign rsp_tdata  = tdata_ff;

endmodule

/* src/multi_channel_quadrature_counter_top.sv */
// Channel   Direction   Payload
// req       in          a_levels, b_levels, clear_mask (one pin sample)
// rsp       out         count_zero .. count_four (counts after the sample)
// csr       in/out      invert_mask at 0x0, channel4_divider at 0x4
//
// One item is accepted every cycle while the output is free or being read;
// its result appears in the cycle after. Each channel lane updates its count
// in the accepting cycle and the output register holds the merged result.
// Reset clears all counts and the channel four sub-count, sets the stored
// A levels high, and loads the registers with their reset values.
// A stalled result holds req_tready low only while it is not taken.
module multi_channel_quadrature_counter_top #(
   parameter int CHANNELS    = 5,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // a_levels [4:0], b_levels [9:5], clear_mask [14:10], zero fill [15].
   input  logic [qec_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // count_zero [31:0], count_one [63:32], count_two [95:64],
   // count_three [127:96], count_four [159:128].
   output logic [qec_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [qec_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [qec_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [qec_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   localparam int LANES = (CHANNELS < qec_pkg::OUT_FIELDS) ? CHANNELS : qec_pkg::OUT_FIELDS;

   logic [qec_pkg::PIN_BITS-1:0]            a_levels;
   logic [qec_pkg::PIN_BITS-1:0]            b_levels;
   logic [qec_pkg::PIN_BITS-1:0]            clear_mask;
   logic [qec_pkg::PIN_BITS-1:0]            prev_a_ff;
   logic [qec_pkg::PIN_BITS-1:0]            prev_a_in;
   logic [qec_pkg::PIN_BITS-1:0]            invert_ff;
   logic [qec_pkg::PIN_BITS-1:0]            invert_in;
   logic [qec_pkg::DIV_WIDTH-1:0]           divider_ff;
   logic [qec_pkg::DIV_WIDTH-1:0]           divider_in;
   logic                                    accept;
   logic                                    space;
   logic                                    csr_write;
   logic [0:0]                              csr_index;
   logic [LANES-1:0][COUNT_WIDTH-1:0]       counts;

   assign a_levels   = req_tdata[4:0];
   assign b_levels   = req_tdata[9:5];
   assign clear_mask = req_tdata[14:10];

   assign req_tready = space;
   assign accept     = req_tvalid && space;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[2:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      invert_in  = invert_ff;
      divider_in = divider_ff;
      if (csr_write) begin
         case (csr_index)
            qec_pkg::CSR_INVERT_MASK: invert_in  = csr_pwdata[qec_pkg::PIN_BITS-1:0];
            qec_pkg::CSR_DIVIDER:     divider_in = csr_pwdata[qec_pkg::DIV_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         qec_pkg::CSR_INVERT_MASK: csr_prdata = qec_pkg::CSR_DATA_WIDTH'(invert_ff);
         qec_pkg::CSR_DIVIDER:     csr_prdata = qec_pkg::CSR_DATA_WIDTH'(divider_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   assign prev_a_in = accept ? a_levels : prev_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_a_ff  <= '1;
         invert_ff  <= '0;
         divider_ff <= qec_pkg::DIVIDER_RESET;
      end else begin
         prev_a_ff  <= prev_a_in;
         invert_ff  <= invert_in;
         divider_ff <= divider_in;
      end
   end

   generate
      for (genvar i = 0; i < LANES; i++) begin : g_lane
         qec_pkg::lane_pins_type pins;

         assign pins.a      = a_levels[i];
         assign pins.b      = b_levels[i];
         assign pins.prev_a = prev_a_ff[i];
         assign pins.clear  = clear_mask[i];
         assign pins.invert = invert_ff[i];

         qec_lane #(
            .COUNT_WIDTH (COUNT_WIDTH),
            .DIVIDED     (i == qec_pkg::DIVIDED_CHANNEL)
         ) u_lane (
            .clock      (clock),
            .reset      (reset),
            .accept     (accept),
            .pins       (pins),
            .divider    (divider_ff),
            .count_next (counts[i])
         );
      end
   endgenerate

   qec_merge #(
      .LANES       (LANES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .counts     (counts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .space      (space)
   );

endmodule

/* dv/multi_channel_quadrature_counter_checker.sv */
module multi_channel_quadrature_counter_checker (
   input  logic                                clock,
   input  logic                                reset,
   // a_levels [4:0], b_levels [9:5], clear_mask [14:10], zero fill [15].
   input  logic [qec_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   // count_zero [31:0] up to count_four [159:128].
   input  logic [qec_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [qec_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [qec_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   input  logic                                csr_pready,
   output int                                  mismatch_count,
   output int                                  counts_pending,
   output int                                  counts_checked
);

   typedef logic [qec_pkg::OUT_FIELDS-1:0][qec_pkg::OUT_WIDTH-1:0] count_set_type;

   string field_names [qec_pkg::OUT_FIELDS] =
      '{"count_zero", "count_one", "count_two", "count_three", "count_four"};

   logic [qec_pkg::PIN_BITS-1:0]         invert_bits;
   logic [qec_pkg::DIV_WIDTH-1:0]        divider;
   logic [qec_pkg::PIN_BITS-1:0]         prior_a;
   count_set_type                        positions;
   logic signed [qec_pkg::SUB_WIDTH-1:0] subcount;
   count_set_type                        expected_counts [$];

   task automatic step_encoders(input logic [qec_pkg::PIN_BITS-1:0] a_pins,
                                input logic [qec_pkg::PIN_BITS-1:0] b_pins,
                                input logic [qec_pkg::PIN_BITS-1:0] clear_pins,
                                output count_set_type after);
      int   ch;
      int   sub;
      int   div;
      logic up;
      div = (divider == '0) ? 1 : int'(divider);
      for (ch = 0; ch < qec_pkg::PIN_BITS; ch++) begin
         if (clear_pins[ch]) begin
            positions[ch] = '0;
            if (ch == qec_pkg::DIVIDED_CHANNEL) begin
               subcount = '0;
            end
         end else if (a_pins[ch] != prior_a[ch]) begin
            up = (a_pins[ch] == b_pins[ch]) ^ invert_bits[ch];
            if (ch == qec_pkg::DIVIDED_CHANNEL) begin
               sub = int'(subcount) + (up ? 1 : -1);
               if (sub >= div) begin
                  positions[ch] = positions[ch] + 1'b1;
                  sub = sub - div;
               end else if (sub <= -div) begin
                  positions[ch] = positions[ch] - 1'b1;
                  sub = sub + div;
               end
               subcount = sub[qec_pkg::SUB_WIDTH-1:0];
            end else begin
               positions[ch] = up ? positions[ch] + 1'b1 : positions[ch] - 1'b1;
            end
         end
      end
      prior_a = a_pins;
      after = positions;
   endtask

   always @(posedge clock) begin : watch
      count_set_type predicted;
      count_set_type observed;
      int            ch;
      if (reset) begin
         invert_bits = '0;
         divider = qec_pkg::DIVIDER_RESET;
         prior_a = '1;
         positions = '0;
         subcount = '0;
         expected_counts.delete();
         mismatch_count = 0;
         counts_checked = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_counts.size() == 0) begin
               $error("result item arrived with no request outstanding");
               mismatch_count++;
            end else begin
               predicted = expected_counts.pop_front();
               observed = rsp_tdata;
               for (ch = 0; ch < qec_pkg::OUT_FIELDS; ch++) begin
                  if (observed[ch] !== predicted[ch]) begin
                     $error("%s expected %0d actual %0d", field_names[ch],
                            $signed(predicted[ch]), $signed(observed[ch]));
                     mismatch_count++;
                  end
               end
               counts_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            step_encoders(req_tdata[4:0], req_tdata[9:5], req_tdata[14:10], predicted);
            expected_counts.push_back(predicted);
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[qec_pkg::CSR_ADDR_WIDTH-1:2])
               qec_pkg::CSR_INVERT_MASK: invert_bits = csr_pwdata[qec_pkg::PIN_BITS-1:0];
               qec_pkg::CSR_DIVIDER:     divider = csr_pwdata[qec_pkg::DIV_WIDTH-1:0];
               default: ;
            endcase
         end
      end
      counts_pending = expected_counts.size();
   end

endmodule

/* dv/tb_multi_channel_quadrature_counter_top.sv */
module tb_multi_channel_quadrature_counter_top;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   // a_levels [4:0], b_levels [9:5], clear_mask [14:10], zero fill [15].
   logic [qec_pkg::REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   // count_zero [31:0], count_one [63:32], count_two [95:64],
   // count_three [127:96], count_four [159:128].
   logic [qec_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic                               csr_psel = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite = 1'b0;
   logic [qec_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [qec_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [qec_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                               csr_pready;

   int mismatch_count;
   int counts_pending;
   int counts_checked;
   int samples_sent = 0;

   logic [1:0]                   gray_phase [qec_pkg::PIN_BITS];
   logic [qec_pkg::PIN_BITS-1:0] heading;

   multi_channel_quadrature_counter_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   multi_channel_quadrature_counter_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_tdata      (req_tdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .counts_pending (counts_pending),
      .counts_checked (counts_checked)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Every fourth stretch of 128 items runs without any idle cycles.
   function automatic int pause_for(input int index);
      if ((index / 128) % 4 == 3) begin
         return 0;
      end
      return int'($urandom_range(0, 8));
   endfunction

   task automatic offer_sample(input logic [qec_pkg::PIN_BITS-1:0] a_pins,
                               input logic [qec_pkg::PIN_BITS-1:0] b_pins,
                               input logic [qec_pkg::PIN_BITS-1:0] clear_pins);
      int gap;
      gap = pause_for(samples_sent);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= {1'b0, clear_pins, b_pins, a_pins};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      samples_sent++;
      @(negedge clock);
   endtask

   // Mostly legal Gray-code motion per channel with a slowly changing
   // direction, plus occasional clears and arbitrary pin noise.
   task automatic encoder_sample();
      logic [qec_pkg::PIN_BITS-1:0] a_pins;
      logic [qec_pkg::PIN_BITS-1:0] b_pins;
      logic [qec_pkg::PIN_BITS-1:0] clear_pins;
      int                           pick;
      int                           ch;
      pick = int'($urandom_range(0, 39));
      clear_pins = '0;
      if (pick == 0) begin
         a_pins = qec_pkg::PIN_BITS'($urandom);
         b_pins = qec_pkg::PIN_BITS'($urandom);
         clear_pins = qec_pkg::PIN_BITS'($urandom);
      end else begin
         if (pick == 1) begin
            clear_pins = qec_pkg::PIN_BITS'($urandom);
         end
         for (ch = 0; ch < qec_pkg::PIN_BITS; ch++) begin
            if ($urandom_range(0, 31) == 0) begin
               heading[ch] = ~heading[ch];
            end
            if ($urandom_range(0, 3) != 0) begin
               gray_phase[ch] = heading[ch] ? gray_phase[ch] + 2'd1 : gray_phase[ch] - 2'd1;
            end
            a_pins[ch] = gray_phase[ch][0] ^ gray_phase[ch][1];
            b_pins[ch] = gray_phase[ch][1];
         end
      end
      offer_sample(a_pins, b_pins, clear_pins);
   endtask

   task automatic write_register(input logic [0:0] index,
                                 input logic [qec_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (counts_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin : drain
      int hold;
      int taken;
      taken = 0;
      @(negedge clock);
      forever begin
         hold = pause_for(taken);
         if (taken == 400) begin
            hold = 150;
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         taken++;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      logic [qec_pkg::PIN_BITS-1:0]  invert_plan [6];
      logic [qec_pkg::DIV_WIDTH-1:0] divider_plan [6];
      int                            setting;
      int                            ch;
      int                            n;
      invert_plan = '{5'h00, 5'h1F, 5'h0A, 5'h15, 5'h00, 5'h00};
      divider_plan = '{qec_pkg::DIVIDER_RESET, 15'd1, 15'd32767, 15'd0, 15'd3, 15'd100};
      invert_plan[4] = qec_pkg::PIN_BITS'($urandom);
      divider_plan[4] = qec_pkg::DIV_WIDTH'($urandom_range(2, 12));
      for (ch = 0; ch < qec_pkg::PIN_BITS; ch++) begin
         gray_phase[ch] = 2'd2;
      end
      heading = qec_pkg::PIN_BITS'($urandom);
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      offer_sample(5'h1F, 5'h1F, 5'h00);
      offer_sample(5'h00, 5'h00, 5'h00);
      offer_sample(5'h1F, 5'h00, 5'h00);
      offer_sample(5'h00, 5'h1F, 5'h00);
      offer_sample(5'h1F, 5'h1F, 5'h1F);
      offer_sample(5'h00, 5'h00, 5'h1F);
      offer_sample(5'h0A, 5'h15, 5'h10);
      offer_sample(5'h15, 5'h0A, 5'h0F);
      offer_sample(5'h1F, 5'h00, 5'h00);
      offer_sample(5'h00, 5'h00, 5'h00);
      offer_sample(5'h1F, 5'h1F, 5'h00);

      for (setting = 0; setting < 6; setting++) begin
         if (setting > 0) begin
            settle();
            write_register(qec_pkg::CSR_INVERT_MASK,
                           qec_pkg::CSR_DATA_WIDTH'(invert_plan[setting]));
            write_register(qec_pkg::CSR_DIVIDER,
                           qec_pkg::CSR_DATA_WIDTH'(divider_plan[setting]));
         end
         for (n = 0; n < 215; n++) begin
            encoder_sample();
         end
      end
      settle();

      $display("Covered %0d pin samples across six register settings, %0d results compared.",
               samples_sent, counts_checked);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* multi_channel_quadrature_counter_top.f */
src/qec_pkg.sv
src/qec_lane.sv
src/qec_merge.sv
src/multi_channel_quadrature_counter_top.sv
dv/multi_channel_quadrature_counter_checker.sv
dv/tb_multi_channel_quadrature_counter_top.sv
